### rtl/wpf_pkg.sv
// Shared constants, types and the offset wrap table of the feedback flanger.
// No dependencies; every other file in rtl/ depends on this package.
`default_nettype none

package wpf_pkg;

  localparam int FRAME_LEN_DEF = 32;

  localparam int SAMPLE_W = 8;
  localparam int LEVEL_W  = 8;
  localparam int AMOUNT_W = 5;

  // (127 - level) * amount fits 13 bits; times 8225 fits 27 bits
  localparam int LEVEL_CEIL = 127;
  localparam int PROD_W     = LEVEL_W + AMOUNT_W;
  localparam int LFO_SCALE  = 8225;
  localparam int LFO_SHIFT  = 21;
  localparam int SCALED_W   = PROD_W + 14;

  // wrap table covers (q - amount) in -32..31, biased by +32
  localparam int LUT_BIAS  = 32;
  localparam int LUT_DEPTH = 64;
  localparam int LUT_IDX_W = 6;
  localparam int LUT_W     = 8;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int REG_IDX_W = CFG_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_LFO_AMOUNT = '0;

  typedef logic [LUT_W-1:0] wrap_lut_t [LUT_DEPTH];

  typedef struct packed {
    logic clr;
    logic step;
    logic swap;
  } cell_ctl_t;

  // Entry i holds (i - LUT_BIAS) reduced into 0..n-1; evaluated at elaboration.
  function automatic wrap_lut_t wrap_lut(input int n);
    wrap_lut_t lut;
    int v;
    for (int i = 0; i < LUT_DEPTH; i++) begin
      v = i - LUT_BIAS;
      for (int k = 0; k < LUT_DEPTH; k++) begin
        if (v < 0) v = v + n;
      end
      for (int k = 0; k < LUT_DEPTH; k++) begin
        if (v >= n) v = v - n;
      end
      lut[i] = LUT_W'(v);
    end
    return lut;
  endfunction

endpackage

`default_nettype wire

### rtl/wpf_if.sv
// Valid/ready stream interfaces for the flanger's sample and result channels.
// Depends on wpf_pkg for field widths.
`default_nettype none

interface wpf_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [wpf_pkg::SAMPLE_W-1:0]   sample;
  logic signed [wpf_pkg::LEVEL_W-1:0]    lfo_level;

  modport source (output valid, output sample, output lfo_level, input ready);
  modport sink   (input valid, input sample, input lfo_level, output ready);
endinterface

interface wpf_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [wpf_pkg::SAMPLE_W-1:0]   mixed_sample;
  logic                                  frame_end;

  modport source (output valid, output mixed_sample, output frame_end, input ready);
  modport sink   (input valid, input mixed_sample, input frame_end, output ready);
endinterface

`default_nettype wire

### rtl/wavetable_phaser_feedback_core.sv
// Feedback flanger over framed 8-bit samples with a two-bank history ring.
// Each result passes the input, offset and mix/output registers before its
// transfer.
// Throughput: one sample per cycle unless out_chan back-pressures; the history cells
// rotate and shift once per effect-on transfer, so the ring never holds up the stream.
// Reset (synchronous, rst_n low): history, frame position, offset, amount cleared.
// Depends on wpf_pkg, wpf_if, wpf_offset and wpf_cell.
`default_nettype none

module wavetable_phaser_feedback_core #(
  parameter  int FRAME_LEN = wpf_pkg::FRAME_LEN_DEF,
  localparam int POS_W     = $clog2(FRAME_LEN)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  wpf_in_if.sink                             in_chan,
  wpf_out_if.source                          out_chan,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [wpf_pkg::CFG_AW-1:0]    paddr,
  input  wire logic [wpf_pkg::CFG_DW-1:0]    pwdata,
  output logic      [wpf_pkg::CFG_DW-1:0]    prdata,
  output logic                               pready
);
  import wpf_pkg::*;

  // configuration
  logic                 cfg_wr;
  logic                 reg_hit;
  logic [AMOUNT_W-1:0]  amount_wdata;
  logic                 hist_clr;
  logic [AMOUNT_W-1:0]  amount_r, amount_nxt;

  // frame position and pipeline control
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic                 in_first, in_last;
  logic                 in_xfer, adv2, adv3;
  logic                 s1_free, s2_free;
  logic [LEVEL_W-1:0]   level_gap;

  logic                 s1_v_r, s1_v_nxt;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic [PROD_W-1:0]    s1_prod_r;
  logic                 s1_first_r, s1_last_r;

  logic                 s2_v_r, s2_v_nxt;
  logic signed [SAMPLE_W-1:0] s2_sample_r;
  logic [POS_W-1:0]     s2_off_r;
  logic                 s2_act_r, s2_last_r;

  logic                 out_v_r, out_v_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                 out_end_r;

  logic [POS_W-1:0]     off_item;
  logic                 act_item;

  // history ring
  cell_ctl_t            cell_ctl;
  logic [SAMPLE_W-1:0]  rd_q [FRAME_LEN];
  logic [SAMPLE_W-1:0]  wr_q [FRAME_LEN];
  logic [SAMPLE_W-1:0]  tap;
  logic signed [SAMPLE_W-1:0] hist;
  logic signed [SAMPLE_W-1:0] mixed;
  logic signed [SAMPLE_W-1:0] result;

  // ---------------- configuration port ----------------
  assign pready       = 1'b1;
  assign cfg_wr       = psel && penable && pwrite && pready;
  assign reg_hit      = (paddr[CFG_AW-1:2] == REG_LFO_AMOUNT);
  assign amount_wdata = pwdata[AMOUNT_W-1:0];
  // a new nonzero amount written over zero wipes both banks
  assign hist_clr     = cfg_wr && reg_hit && (amount_r == '0) && (amount_wdata != amount_r);
  assign amount_nxt   = (cfg_wr && reg_hit) ? amount_wdata : amount_r;
  assign prdata       = reg_hit ? CFG_DW'(amount_r) : '0;

  // ---------------- handshake ----------------
  assign adv3    = s2_v_r && (!out_v_r || out_chan.ready);
  assign s2_free = !s2_v_r || adv3;
  assign adv2    = s1_v_r && s2_free;
  assign s1_free = !s1_v_r || adv2;
  assign in_chan.ready = s1_free;
  assign in_xfer = in_chan.valid && s1_free;

  assign in_first  = (pos_r == '0);
  assign in_last   = (pos_r == POS_W'(FRAME_LEN - 1));
  assign pos_nxt   = !in_xfer ? pos_r : (in_last ? '0 : POS_W'(pos_r + 1'b1));
  assign level_gap = LEVEL_W'(LEVEL_CEIL) - in_chan.lfo_level;

  assign s1_v_nxt  = in_xfer ? 1'b1 : (adv2 ? 1'b0 : s1_v_r);
  assign s2_v_nxt  = adv2 ? 1'b1 : (adv3 ? 1'b0 : s2_v_r);
  assign out_v_nxt = adv3 ? 1'b1 : (out_chan.ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amount_r <= '0;
      pos_r    <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      amount_r <= amount_nxt;
      pos_r    <= pos_nxt;
      s1_v_r   <= s1_v_nxt;
      s2_v_r   <= s2_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // ---------------- stage 1: take the sample, form the LFO product ----------------
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_sample_r <= in_chan.sample;
      s1_prod_r   <= PROD_W'(level_gap) * PROD_W'(amount_r);
      s1_first_r  <= in_first;
      s1_last_r   <= in_last;
    end
  end

  // ---------------- stage 2: offset and effect-on flag ----------------
  wpf_offset #(
    .FRAME_LEN (FRAME_LEN)
  ) u_offset (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv2),
    .first  (s1_first_r),
    .prod   (s1_prod_r),
    .amount (amount_r),
    .off_o  (off_item),
    .act_o  (act_item)
  );

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_sample_r <= s1_sample_r;
      s2_off_r    <= off_item;
      s2_act_r    <= act_item;
      s2_last_r   <= s1_last_r;
    end
  end

  // ---------------- stage 3: tap the ring, mix, feed the write bank ----------------
  // cell j of the read bank holds frame position (pos + j) mod FRAME_LEN
  always_comb begin
    tap = '0;
    for (int j = 0; j < FRAME_LEN; j++) begin
      if (POS_W'(j) == s2_off_r) tap = tap | rd_q[j];
    end
  end

  assign hist   = tap;
  assign mixed  = (s2_sample_r >>> 1) + (hist >>> 1);
  assign result = s2_act_r ? mixed : s2_sample_r;

  assign cell_ctl.clr  = hist_clr;
  assign cell_ctl.step = adv3 && s2_act_r;
  assign cell_ctl.swap = s2_last_r;

  for (genvar j = 0; j < FRAME_LEN; j++) begin : g_cell
    localparam int NXT = (j + 1) % FRAME_LEN;
    logic [SAMPLE_W-1:0] wr_feed;

    if (j == FRAME_LEN - 1) begin : g_tail
      assign wr_feed = result;
    end else begin : g_body
      assign wr_feed = wr_q[j + 1];
    end

    wpf_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (cell_ctl),
      .rd_in (rd_q[NXT]),
      .wr_in (wr_feed),
      .rd_q  (rd_q[j]),
      .wr_q  (wr_q[j])
    );
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (adv3) begin
      out_sample_r <= result;
      out_end_r    <= s2_last_r;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.mixed_sample = out_sample_r;
  assign out_chan.frame_end    = out_end_r;

endmodule

`default_nettype wire

### rtl/wpf_cell.sv
// One history cell: one read-bank sample and one write-bank sample.
// Depends on wpf_pkg (cell_ctl_t, SAMPLE_W).
`default_nettype none

module wpf_cell (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire wpf_pkg::cell_ctl_t              ctl,
  input  wire logic [wpf_pkg::SAMPLE_W-1:0]    rd_in,
  input  wire logic [wpf_pkg::SAMPLE_W-1:0]    wr_in,
  output logic      [wpf_pkg::SAMPLE_W-1:0]    rd_q,
  output logic      [wpf_pkg::SAMPLE_W-1:0]    wr_q
);
  import wpf_pkg::*;

  logic [SAMPLE_W-1:0] rd_r, rd_nxt;
  logic [SAMPLE_W-1:0] wr_r, wr_nxt;

  // Read bank rotates toward cell 0; write bank shifts toward cell 0.
  // On the frame's last transfer the shifted write bank becomes the read bank.
  always_comb begin
    rd_nxt = rd_r;
    wr_nxt = wr_r;
    if (ctl.clr) begin
      rd_nxt = '0;
      wr_nxt = '0;
    end else if (ctl.step) begin
      wr_nxt = wr_in;
      rd_nxt = ctl.swap ? wr_in : rd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0;
      wr_r <= '0;
    end else begin
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
    end
  end

  assign rd_q = rd_r;
  assign wr_q = wr_r;

endmodule

`default_nettype wire

### rtl/wpf_offset.sv
// Delay offset unit: scales the LFO product, wraps it into the frame and
// latches offset and effect-on flag at each frame start. Depends on wpf_pkg.
`default_nettype none

module wpf_offset #(
  parameter  int FRAME_LEN = wpf_pkg::FRAME_LEN_DEF,
  localparam int POS_W     = $clog2(FRAME_LEN)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            adv,
  input  wire logic                            first,
  input  wire logic [wpf_pkg::PROD_W-1:0]      prod,
  input  wire logic [wpf_pkg::AMOUNT_W-1:0]    amount,
  output logic      [POS_W-1:0]                off_o,
  output logic                                 act_o
);
  import wpf_pkg::*;

  localparam wrap_lut_t WRAP = wrap_lut(FRAME_LEN);

  logic [SCALED_W-1:0]  scaled;
  logic [AMOUNT_W-1:0]  swing;
  logic [LUT_IDX_W-1:0] lut_idx;
  logic [POS_W-1:0]     off_new;
  logic                 act_new;
  logic [POS_W-1:0]     off_r, off_nxt;
  logic                 act_r, act_nxt;

  always_comb begin
    scaled  = SCALED_W'(prod) * SCALED_W'(LFO_SCALE);
    swing   = scaled[LFO_SHIFT +: AMOUNT_W];
    lut_idx = LUT_IDX_W'((LUT_IDX_W + 1)'(swing) + (LUT_IDX_W + 1)'(LUT_BIAS)
                         - (LUT_IDX_W + 1)'(amount));
    off_new = POS_W'(WRAP[lut_idx]);
    act_new = (amount != '0);

    off_o = first ? off_new : off_r;
    act_o = first ? act_new : act_r;

    off_nxt = (adv && first) ? off_new : off_r;
    act_nxt = (adv && first) ? act_new : act_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
      act_r <= 1'b0;
    end else begin
      off_r <= off_nxt;
      act_r <= act_nxt;
    end
  end

endmodule

`default_nettype wire

### verif/wavetable_phaser_feedback_core_test.sv
// Self-checking bench for the feedback flanger core: a queue-fed sample driver,
// an in-bench flanger predictor, a result monitor and APB writes of lfo_amount.
// Depends on wpf_pkg, wpf_if and the core RTL.
`timescale 1ns / 1ps

module wavetable_phaser_feedback_core_test;
  import wpf_pkg::*;

  localparam int FRAME_LEN   = FRAME_LEN_DEF;
  localparam int TAP_CEIL    = 127;
  localparam int TAP_SCALE   = 8225;
  localparam int TAP_SHIFT   = 21;
  localparam int STALL_LEN   = 400;
  localparam int NUM_PHASES  = 16;
  localparam int REPORT_MAX  = 10;
  localparam logic [CFG_AW-1:0] AMOUNT_ADDR = {REG_LFO_AMOUNT, 2'b00};

  typedef enum int {PACE_RX_SLOW, PACE_TX_SLOW, PACE_FULL} pace_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [LEVEL_W-1:0]  level;
  } sample_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mixed;
    logic                       frame_end;
  } mix_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  wpf_in_if  in_bus();
  wpf_out_if out_bus();

  wavetable_phaser_feedback_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_bus),
    .out_chan(out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // flanger state mirrored by the bench
  logic signed [SAMPLE_W-1:0] hist_bank [2][FRAME_LEN];
  logic                       read_bank = 1'b0;
  int                         frame_pos = 0;
  int                         tap_offset = 0;
  logic                       effect_on = 1'b0;
  logic [AMOUNT_W-1:0]        amount_reg = '0;

  sample_item_t sample_backlog [$];
  mix_result_t  mix_expect_q [$];
  int           mismatch_count = 0;
  int           gen_count = 0;
  pace_t        pace = PACE_RX_SLOW;
  int           send_idle_pct = 38;
  int           recv_idle_pct = 82;
  int           stall_left = 0;
  logic         stall_done = 1'b0;

  function automatic void clear_history();
    for (int b = 0; b < 2; b++)
      for (int i = 0; i < FRAME_LEN; i++)
        hist_bank[b][i] = '0;
  endfunction

  function automatic void set_amount(input logic [AMOUNT_W-1:0] v);
    if (v != amount_reg) begin
      if (amount_reg == 0) clear_history();
      amount_reg = v;
    end
  endfunction

  function automatic void flange_sample(input logic signed [SAMPLE_W-1:0] s,
                                        input logic signed [LEVEL_W-1:0] lvl);
    int swing;
    int rd_idx;
    int mix;
    logic signed [SAMPLE_W-1:0] h;
    mix_result_t r;
    if (frame_pos == 0) begin
      swing = (TAP_CEIL - int'(lvl)) * int'(amount_reg) * TAP_SCALE;
      tap_offset = ((swing >> TAP_SHIFT) + FRAME_LEN - int'(amount_reg)) % FRAME_LEN;
      effect_on = (amount_reg != 0);
    end
    if (effect_on) begin
      rd_idx = (frame_pos + tap_offset) % FRAME_LEN;
      h = hist_bank[read_bank][rd_idx];
      // each half floors toward minus infinity
      mix = (int'(s) >>> 1) + (int'(h) >>> 1);
      r.mixed = mix[SAMPLE_W-1:0];
      hist_bank[read_bank ^ 1'b1][frame_pos] = r.mixed;
    end else begin
      r.mixed = s;
    end
    r.frame_end = (frame_pos == FRAME_LEN - 1);
    if (r.frame_end) begin
      frame_pos = 0;
      if (effect_on) read_bank = ~read_bank;
    end else begin
      frame_pos = frame_pos + 1;
    end
    mix_expect_q.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic set_pace(input pace_t p);
    pace = p;
    case (p)
      PACE_RX_SLOW: begin
        send_idle_pct = 38;
        recv_idle_pct = 82;
      end
      PACE_TX_SLOW: begin
        send_idle_pct = 82;
        recv_idle_pct = 38;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic apb_write(input logic [CFG_AW-1:0] a, input logic [CFG_DW-1:0] d);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read(input logic [CFG_AW-1:0] a, output logic [CFG_DW-1:0] d);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= a;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    d = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // write lfo_amount, update the mirror and check the readback
  task automatic program_amount(input logic [AMOUNT_W-1:0] v);
    logic [CFG_DW-1:0] rd;
    apb_write(AMOUNT_ADDR, CFG_DW'(v));
    set_amount(v);
    apb_read(AMOUNT_ADDR, rd);
    if (rd !== CFG_DW'(amount_reg))
      report_mismatch("lfo_amount readback", int'(amount_reg), int'(rd));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (sample_backlog.size() != 0 || in_bus.valid || mix_expect_q.size() != 0);
  endtask

  task automatic queue_sample(input logic signed [SAMPLE_W-1:0] s,
                              input logic signed [LEVEL_W-1:0] lvl);
    sample_item_t it;
    it.sample = s;
    it.level = lvl;
    sample_backlog.push_back(it);
    gen_count++;
  endtask

  task automatic queue_random(input int n);
    logic signed [SAMPLE_W-1:0] s;
    logic signed [LEVEL_W-1:0] lvl;
    for (int k = 0; k < n; k++) begin
      s = SAMPLE_W'($urandom_range(255, 0));
      if ($urandom_range(7, 0) == 0) s = ($urandom_range(1, 0) != 0) ? 8'sd127 : -8'sd128;
      lvl = LEVEL_W'($urandom_range(255, 0));
      // push the level extremes onto frame starts, where the offset is latched
      if (gen_count % FRAME_LEN == 0) begin
        case ($urandom_range(3, 0))
          0: lvl = -8'sd128;
          1: lvl = 8'sd127;
          default: ;
        endcase
      end
      queue_sample(s, lvl);
    end
  endtask

  // sample driver
  always @(posedge clk) begin : sample_driver
    sample_item_t nxt;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.sample <= '0;
      in_bus.lfo_level <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) flange_sample(in_bus.sample, in_bus.lfo_level);
      if (!in_bus.valid || in_bus.ready) begin
        if (sample_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          nxt = sample_backlog.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.sample <= nxt.sample;
          in_bus.lfo_level <= nxt.level;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once the sender runs flat out
  always @(posedge clk) begin : receiver_hold
    if (!rst_n) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!stall_done && pace == PACE_FULL && in_bus.valid) begin
      stall_left <= STALL_LEN;
      stall_done <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    mix_result_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (mix_expect_q.size() == 0) begin
          report_mismatch("unexpected result transfer", 0, 1);
        end else begin
          want = mix_expect_q.pop_front();
          if (out_bus.mixed_sample !== want.mixed)
            report_mismatch("mixed_sample", int'(want.mixed), int'(out_bus.mixed_sample));
          if (out_bus.frame_end !== want.frame_end)
            report_mismatch("frame_end", int'(want.frame_end), int'(out_bus.frame_end));
        end
      end
      out_bus.ready <= ($urandom_range(99, 0) >= recv_idle_pct) && (stall_left == 0);
    end
  end

  initial begin : watchdog
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [AMOUNT_W-1:0] amount_plan [NUM_PHASES];
    logic [CFG_DW-1:0] rd;
    amount_plan = '{5'd31, 5'd31, 5'd1, 5'd0, 5'd0, 5'd17, 5'd0, 5'd31,
                    5'd8, 5'd0, 5'd1, 5'd23, 5'd2, 5'd0, 5'd30, 5'd16};
    clear_history();
    set_pace(PACE_RX_SLOW);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    apb_read(AMOUNT_ADDR, rd);
    if (rd !== CFG_DW'(amount_reg))
      report_mismatch("lfo_amount after reset", int'(amount_reg), int'(rd));
    // same value while bypassed: no clear
    program_amount(5'd0);

    @(negedge clk);
    queue_sample(-8'sd128, -8'sd128);
    queue_sample(8'sd127, 8'sd127);
    queue_sample(-8'sd1, 8'sd0);
    queue_sample(8'sd0, -8'sd1);
    queue_sample(8'sd1, 8'sd1);
    queue_sample(-8'sd2, -8'sd128);
    queue_sample(8'sd85, 8'sd127);
    queue_sample(-8'sd86, -8'sd86);
    wait_drained();

    // amount from zero mid-frame: clears now, takes effect at next frame start
    program_amount(5'd31);
    @(negedge clk);
    for (int k = 0; k < 12; k++)
      queue_sample((k % 2 != 0) ? 8'sd127 : -8'sd128, (k % 3 != 0) ? 8'sd127 : -8'sd128);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_pace(p < 6 ? PACE_RX_SLOW : (p < 11 ? PACE_TX_SLOW : PACE_FULL));
      program_amount(amount_plan[p]);
      @(negedge clk);
      queue_random($urandom_range(140, 55));
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/wpf_pkg.sv
rtl/wpf_if.sv
rtl/wpf_cell.sv
rtl/wpf_offset.sv
rtl/wavetable_phaser_feedback_core.sv
verif/wavetable_phaser_feedback_core_test.sv
